@@ sv/nrsp_pkg.sv @@
`default_nettype none
package nrsp_pkg;

  // fixed-point one in Q16.16
  localparam logic [16:0] ONE_Q16 = 17'h10000;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_ORIGIN_X = 3'd0,
    REG_ORIGIN_Y = 3'd1,
    REG_ORIGIN_Z = 3'd2,
    REG_AIM_X    = 3'd3,
    REG_AIM_Y    = 3'd4,
    REG_AIM_Z    = 3'd5,
    REG_RADIUS   = 3'd6,
    REG_REACH    = 3'd7
  } cfg_reg_t;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_ACC, S_PROJ, S_SQST, S_SQW, S_DVST, S_DVW, S_ITEM, S_OCHK, S_FIN
  } state_t;

  // what the shared multiplier is working on
  typedef enum logic [2:0] {
    J_AIM, J_O2, J_PJ, J_B2, J_R2
  } job_t;

  // magnitude of a 33-bit signed value
  function automatic logic [32:0] mag33(input logic [32:0] v);
    mag33 = v[32] ? 33'(~v + 33'd1) : v;
  endfunction

  // magnitude of a 36-bit signed value
  function automatic logic [35:0] mag36(input logic [35:0] v);
    mag36 = v[35] ? 36'(~v + 36'd1) : v;
  endfunction

endpackage
`default_nettype wire

@@ sv/nrsp_mul.sv @@
`default_nettype none
module nrsp_mul (
  input  wire logic        clk,
  input  wire logic [31:0] a,
  input  wire logic [31:0] b,
  output logic [63:0]      p_r
);

  // registered unsigned product
  always_ff @(posedge clk) begin
    p_r <= 64'(a) * 64'(b);
  end

endmodule
`default_nettype wire

@@ sv/nrsp_sqrt.sv @@
`default_nettype none
module nrsp_sqrt (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [63:0] val,
  output logic             done_r,
  output logic [31:0]      root
);

  logic [63:0] rem_r;
  logic [63:0] res_r;
  logic [63:0] bit_r;
  logic [4:0]  cnt_r;
  logic        busy_r;
  logic [63:0] trial;

  assign trial = res_r + bit_r;
  assign root  = res_r[31:0];

  // control: 32 digit steps
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // one result bit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= val;
      res_r <= '0;
      bit_r <= 64'h4000_0000_0000_0000;
    end else if (busy_r) begin
      if (rem_r >= trial) begin
        rem_r <= rem_r - trial;
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

endmodule
`default_nettype wire

@@ sv/nrsp_div.sv @@
`default_nettype none
module nrsp_div (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [31:0] num,
  input  wire logic [31:0] den,
  output logic             done_r,
  output logic [16:0]      quo
);

  logic [31:0] rem_r;
  logic [31:0] den_r;
  logic [15:0] q_r;
  logic        zero_r;
  logic        ovf_r;
  logic [3:0]  cnt_r;
  logic        busy_r;
  logic [32:0] rem2;

  assign rem2 = {rem_r, 1'b0};
  assign quo  = zero_r ? 17'd0 : (ovf_r ? nrsp_pkg::ONE_Q16 : {1'b0, q_r});

  // control: 16 quotient bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 4'd1;
        if (cnt_r == 4'd15) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // restoring division, one bit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= num;
      den_r  <= den;
      q_r    <= '0;
      zero_r <= (den == 32'd0);
      ovf_r  <= (num >= den);
    end else if (busy_r) begin
      if (rem2 >= {1'b0, den_r}) begin
        rem_r <= 32'(rem2 - {1'b0, den_r});
        q_r   <= {q_r[14:0], 1'b1};
      end else begin
        rem_r <= rem2[31:0];
        q_r   <= {q_r[14:0], 1'b0};
      end
    end
  end

endmodule
`default_nettype wire

@@ sv/nearest_ray_sphere_pick.sv @@
// nearest ray-sphere pick: one candidate sphere per transfer, one result per query
// a candidate that passes screening runs the 32-step square root when its discriminant is
//   non-negative; the first of a query also runs one for the aim length and three 16-step
//   divides for direction normalising
// throughput: one candidate at a time; the input stalls while the sequencer is busy
// reset: rst_n synchronous active low; registers take their reset values, no query open
`default_nettype none
module nearest_ray_sphere_pick (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] in_item_id,
  input  wire logic [31:0] in_centre_x,
  input  wire logic [31:0] in_centre_y,
  input  wire logic [31:0] in_centre_z,
  input  wire logic        in_same_dimension,
  input  wire logic        in_last_item,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_found,
  output logic [31:0]      out_best_id,
  output logic [30:0]      out_best_distance
);

  // configuration
  logic [31:0] origin_r [3];
  logic [31:0] aim_r [3];
  logic [30:0] radius_r;
  logic [30:0] reach_r;

  // item
  logic [31:0] id_r;
  logic [31:0] cen_r [3];
  logic        same_r;
  logic        last_r;

  // sequencer
  nrsp_pkg::state_t state_r, state_nxt;
  nrsp_pkg::job_t   job_r, job_nxt;
  logic [1:0]       idx_r, idx_nxt;
  logic             nrm_r;
  logic             query_open_r;

  // datapath
  logic [63:0] acc_r;
  logic [63:0] o2_r;
  logic [63:0] b2_r;
  logic signed [50:0] proj_r;
  logic [34:0] b_r;
  logic [32:0] o_r [3];
  logic [17:0] udir_r [3];
  logic [31:0] len_r;

  // kept hit and result
  logic        have_r;
  logic [31:0] kid_r;
  logic [30:0] kdist_r;
  logic        out_valid_r;
  logic        out_found_r;
  logic [31:0] out_id_r;
  logic [30:0] out_dist_r;

  logic        accept, out_free;
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic        sq_start, sq_done;
  logic [31:0] sq_root;
  logic        dv_start, dv_done;
  logic [16:0] dv_quo;
  logic [31:0] aim_sel;
  logic [32:0] aim_m33, o_m33, u_m33;
  logic [32:0] om0_m33, om1_m33, om2_m33;
  logic [31:0] aim_mag;
  logic [31:0] o_mag;
  logic [31:0] u_mag;
  logic [35:0] b_mag;
  logic [31:0] bm_sat;
  logic [50:0] pj_term;
  logic        pj_neg;
  logic        skip;
  logic        far_off;
  logic [63:0] d_hi, d_lo;
  logic [64:0] d_sum;
  logic        disc_ok;
  logic [63:0] disc_val;
  logic [35:0] nb, far_v, near_v, near_c;
  logic        hit_ok;
  logic        better;
  logic [30:0] hit_len;

  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_found = out_found_r;
  assign out_best_id       = out_id_r;
  assign out_best_distance = out_dist_r;

  // shared multiplier and square root, divider for direction normalising
  nrsp_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p_r(mul_p));

  nrsp_sqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .start(sq_start), .val(acc_r),
    .done_r(sq_done), .root(sq_root)
  );

  nrsp_div u_div (
    .clk(clk), .rst_n(rst_n), .start(dv_start), .num(aim_mag), .den(len_r),
    .done_r(dv_done), .quo(dv_quo)
  );

  // operand magnitudes for the selected component
  assign aim_sel = aim_r[idx_r];
  assign aim_m33 = nrsp_pkg::mag33({aim_sel[31], aim_sel});
  assign o_m33   = nrsp_pkg::mag33(o_r[idx_r]);
  assign u_m33   = nrsp_pkg::mag33({{15{udir_r[idx_r][17]}}, udir_r[idx_r]});
  assign aim_mag = aim_m33[31:0];
  assign o_mag   = o_m33[31:0];
  assign u_mag   = {14'd0, u_m33[17:0]};
  assign b_mag   = nrsp_pkg::mag36({b_r[34], b_r});
  assign bm_sat  = (|b_mag[35:32]) ? 32'hFFFF_FFFF : b_mag[31:0];

  // signed projection term
  assign pj_neg  = o_r[idx_r][32] ^ udir_r[idx_r][17];
  assign pj_term = pj_neg ? 51'(~{3'd0, mul_p[47:0]} + 51'd1) : {3'd0, mul_p[47:0]};

  // candidate screening
  assign om0_m33 = nrsp_pkg::mag33(o_r[0]);
  assign om1_m33 = nrsp_pkg::mag33(o_r[1]);
  assign om2_m33 = nrsp_pkg::mag33(o_r[2]);
  assign skip = (id_r == 32'd0) || !same_r || (radius_r == 31'd0) || (reach_r == 31'd0)
             || ((udir_r[0] == 18'd0) && (udir_r[1] == 18'd0) && (udir_r[2] == 18'd0));
  assign far_off = (|om0_m33[32:31]) || (|om1_m33[32:31]) || (|om2_m33[32:31]);

  // discriminant with r^2 from the multiplier
  assign d_hi  = b2_r - o2_r;
  assign d_lo  = o2_r - b2_r;
  assign d_sum = {1'b0, d_hi} + {1'b0, mul_p};
  always_comb begin
    disc_ok  = 1'b1;
    disc_val = '0;
    if (b2_r >= o2_r) begin
      disc_val = d_sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : d_sum[63:0];
    end else if (mul_p < d_lo) begin
      disc_ok = 1'b0;
    end else begin
      disc_val = mul_p - d_lo;
    end
  end

  // near and far distances
  assign nb      = 36'(~{b_r[34], b_r} + 36'd1);
  assign far_v   = nb + {4'd0, sq_root};
  assign near_v  = nb - {4'd0, sq_root};
  assign near_c  = near_v[35] ? 36'd0 : near_v;
  assign hit_ok  = !far_v[35] && (near_c <= {5'd0, reach_r});
  assign hit_len = near_c[30:0];
  assign better  = !have_r || (hit_len < kdist_r) || ((hit_len == kdist_r) && (id_r < kid_r));

  // sequencer next state and unit controls
  always_comb begin
    state_nxt = state_r;
    job_nxt   = job_r;
    idx_nxt   = idx_r;
    in_stall  = 1'b1;
    sq_start  = 1'b0;
    dv_start  = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    unique case (job_r)
      nrsp_pkg::J_AIM: begin
        mul_a = aim_mag;
        mul_b = aim_mag;
      end
      nrsp_pkg::J_O2: begin
        mul_a = o_mag;
        mul_b = o_mag;
      end
      nrsp_pkg::J_PJ: begin
        mul_a = o_mag;
        mul_b = u_mag;
      end
      nrsp_pkg::J_B2: begin
        mul_a = bm_sat;
        mul_b = bm_sat;
      end
      nrsp_pkg::J_R2: begin
        mul_a = {1'b0, radius_r};
        mul_b = {1'b0, radius_r};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    unique case (state_r)
      nrsp_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (query_open_r) begin
            state_nxt = nrsp_pkg::S_ITEM;
          end else begin
            state_nxt = nrsp_pkg::S_MUL;
            job_nxt   = nrsp_pkg::J_AIM;
            idx_nxt   = 2'd0;
          end
        end
      end
      nrsp_pkg::S_MUL: begin
        state_nxt = nrsp_pkg::S_ACC;
      end
      nrsp_pkg::S_ACC: begin
        state_nxt = nrsp_pkg::S_MUL;
        idx_nxt   = idx_r + 2'd1;
        unique case (job_r)
          nrsp_pkg::J_AIM: begin
            if (idx_r == 2'd2) state_nxt = nrsp_pkg::S_SQST;
          end
          nrsp_pkg::J_O2: begin
            if (idx_r == 2'd2) begin
              job_nxt = nrsp_pkg::J_PJ;
              idx_nxt = 2'd0;
            end
          end
          nrsp_pkg::J_PJ: begin
            if (idx_r == 2'd2) state_nxt = nrsp_pkg::S_PROJ;
          end
          nrsp_pkg::J_B2: begin
            job_nxt = nrsp_pkg::J_R2;
          end
          nrsp_pkg::J_R2: begin
            state_nxt = disc_ok ? nrsp_pkg::S_SQST : nrsp_pkg::S_FIN;
          end
          default: state_nxt = nrsp_pkg::S_FIN;
        endcase
      end
      nrsp_pkg::S_PROJ: begin
        state_nxt = nrsp_pkg::S_MUL;
        job_nxt   = nrsp_pkg::J_B2;
      end
      nrsp_pkg::S_SQST: begin
        sq_start  = 1'b1;
        state_nxt = nrsp_pkg::S_SQW;
      end
      nrsp_pkg::S_SQW: begin
        if (sq_done) begin
          if (nrm_r) begin
            state_nxt = nrsp_pkg::S_DVST;
            idx_nxt   = 2'd0;
          end else begin
            state_nxt = nrsp_pkg::S_FIN;
          end
        end
      end
      nrsp_pkg::S_DVST: begin
        dv_start  = 1'b1;
        state_nxt = nrsp_pkg::S_DVW;
      end
      nrsp_pkg::S_DVW: begin
        if (dv_done) begin
          idx_nxt   = idx_r + 2'd1;
          state_nxt = (idx_r == 2'd2) ? nrsp_pkg::S_ITEM : nrsp_pkg::S_DVST;
        end
      end
      nrsp_pkg::S_ITEM: begin
        state_nxt = skip ? nrsp_pkg::S_FIN : nrsp_pkg::S_OCHK;
      end
      nrsp_pkg::S_OCHK: begin
        if (far_off) begin
          state_nxt = nrsp_pkg::S_FIN;
        end else begin
          state_nxt = nrsp_pkg::S_MUL;
          job_nxt   = nrsp_pkg::J_O2;
          idx_nxt   = 2'd0;
        end
      end
      nrsp_pkg::S_FIN: begin
        if (!last_r || out_free) state_nxt = nrsp_pkg::S_IDLE;
      end
      default: state_nxt = nrsp_pkg::S_IDLE;
    endcase
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_r[0] <= '0;
      origin_r[1] <= '0;
      origin_r[2] <= '0;
      aim_r[0]    <= '0;
      aim_r[1]    <= '0;
      aim_r[2]    <= 32'h0001_0000;
      radius_r    <= 31'h0001_0000;
      reach_r     <= 31'h0005_0000;
    end else if (cfg_we) begin
      unique case (nrsp_pkg::cfg_reg_t'(cfg_index))
        nrsp_pkg::REG_ORIGIN_X: origin_r[0] <= cfg_data;
        nrsp_pkg::REG_ORIGIN_Y: origin_r[1] <= cfg_data;
        nrsp_pkg::REG_ORIGIN_Z: origin_r[2] <= cfg_data;
        nrsp_pkg::REG_AIM_X:    aim_r[0]    <= cfg_data;
        nrsp_pkg::REG_AIM_Y:    aim_r[1]    <= cfg_data;
        nrsp_pkg::REG_AIM_Z:    aim_r[2]    <= cfg_data;
        nrsp_pkg::REG_RADIUS:   radius_r    <= cfg_data[30:0];
        nrsp_pkg::REG_REACH:    reach_r     <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= nrsp_pkg::S_IDLE;
      job_r   <= nrsp_pkg::J_AIM;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      job_r   <= job_nxt;
      idx_r   <= idx_nxt;
    end
  end

  // query control, kept hit and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nrm_r        <= 1'b0;
      query_open_r <= 1'b0;
      have_r       <= 1'b0;
      kid_r        <= '0;
      kdist_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      // result handshake
      if (state_r == nrsp_pkg::S_FIN && last_r && out_free) out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      if (accept && !query_open_r) nrm_r <= 1'b1;
      // end of normalising opens the query
      if (state_r == nrsp_pkg::S_DVW && dv_done && idx_r == 2'd2) begin
        nrm_r        <= 1'b0;
        query_open_r <= 1'b1;
        have_r       <= 1'b0;
        kid_r        <= '0;
        kdist_r      <= '0;
      end
      // keep nearest hit, ties to the smaller id
      if (state_r == nrsp_pkg::S_SQW && sq_done && !nrm_r && hit_ok && better) begin
        have_r  <= 1'b1;
        kid_r   <= id_r;
        kdist_r <= hit_len;
      end
      // report at the last item
      if (state_r == nrsp_pkg::S_FIN && last_r && out_free) begin
        query_open_r <= 1'b0;
        have_r       <= 1'b0;
        kid_r        <= '0;
        kdist_r      <= '0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      id_r     <= in_item_id;
      cen_r[0] <= in_centre_x;
      cen_r[1] <= in_centre_y;
      cen_r[2] <= in_centre_z;
      same_r   <= in_same_dimension;
      last_r   <= in_last_item;
      acc_r    <= '0;
    end
    if (state_r == nrsp_pkg::S_ACC) begin
      case (job_r)
        nrsp_pkg::J_AIM: acc_r  <= acc_r + mul_p;
        nrsp_pkg::J_O2:  o2_r   <= o2_r + mul_p;
        nrsp_pkg::J_PJ:  proj_r <= proj_r + $signed(pj_term);
        nrsp_pkg::J_B2:  b2_r   <= mul_p;
        nrsp_pkg::J_R2:  acc_r  <= disc_val;
        default: ;
      endcase
    end
    if (state_r == nrsp_pkg::S_PROJ) b_r <= proj_r[50:16];
    if (state_r == nrsp_pkg::S_ITEM) begin
      o_r[0] <= {origin_r[0][31], origin_r[0]} - {cen_r[0][31], cen_r[0]};
      o_r[1] <= {origin_r[1][31], origin_r[1]} - {cen_r[1][31], cen_r[1]};
      o_r[2] <= {origin_r[2][31], origin_r[2]} - {cen_r[2][31], cen_r[2]};
    end
    if (state_r == nrsp_pkg::S_OCHK) begin
      o2_r   <= '0;
      proj_r <= '0;
    end
    if (state_r == nrsp_pkg::S_SQW && sq_done && nrm_r) len_r <= sq_root;
    if (state_r == nrsp_pkg::S_DVW && dv_done) begin
      udir_r[idx_r] <= aim_sel[31] ? 18'(~{1'b0, dv_quo} + 18'd1) : {1'b0, dv_quo};
    end
    if (state_r == nrsp_pkg::S_FIN && last_r && out_free) begin
      out_found_r <= have_r;
      out_id_r    <= kid_r;
      out_dist_r  <= kdist_r;
    end
  end

endmodule
`default_nettype wire

@@ tb/sv/testbench.sv @@
`timescale 1ns / 100ps
`default_nettype none
module testbench;

  // one reported pick
  typedef struct packed {
    logic        found;
    logic [31:0] id;
    logic [30:0] best_len;
  } pick_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  nrsp_pkg::cfg_reg_t cfg_index = nrsp_pkg::REG_ORIGIN_X;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] in_item_id = '0;
  logic [31:0] in_centre_x = '0;
  logic [31:0] in_centre_y = '0;
  logic [31:0] in_centre_z = '0;
  logic        in_same_dimension = 1'b0;
  logic        in_last_item = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_found;
  logic [31:0] out_best_id;
  logic [30:0] out_best_distance;

  nearest_ray_sphere_pick uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_item_id(in_item_id),
    .in_centre_x(in_centre_x), .in_centre_y(in_centre_y), .in_centre_z(in_centre_z),
    .in_same_dimension(in_same_dimension), .in_last_item(in_last_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_found(out_found),
    .out_best_id(out_best_id), .out_best_distance(out_best_distance)
  );

  always #10 clk = ~clk;

  // shared bookkeeping
  pick_t  expected_picks[$];
  int     error_count = 0;
  int     picks_checked = 0;
  int     hits_seen = 0;
  int     items_sent = 0;
  bit     idle_on = 1'b1;
  int     rx_hold_left = 0;

  // predictor copy of registers and query state
  longint    ray_org[3];
  longint    ray_aim[3];
  longint    sphere_r;
  longint    reach_max;
  longint    unit_dir[3];
  bit        have_best;
  logic [31:0] best_id_q;
  longint    best_dist_q;
  bit        query_open;

  function automatic longint unsigned root64(input longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'h4000_0000_0000_0000;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint unsigned mag(input longint v);
    return (v < 0) ? longint'(-v) : v;
  endfunction

  // direction normalising at query start
  function automatic void make_unit_dir();
    longint unsigned sum, len;
    longint u;
    sum = 0;
    for (int i = 0; i < 3; i++) sum += mag(ray_aim[i]) * mag(ray_aim[i]);
    len = root64(sum);
    for (int i = 0; i < 3; i++) begin
      u = 0;
      if (len != 0) u = (ray_aim[i] * 65536) / longint'(len);
      if (u > 65536) u = 65536;
      if (u < -65536) u = -65536;
      unit_dir[i] = u;
    end
  endfunction

  // distance to one sphere, -1 when rejected
  function automatic longint ray_hit_dist(input longint cx, input longint cy, input longint cz);
    longint o[3];
    longint proj, b, root, nearv, farv;
    longint unsigned o2, bm, b2, r2, d, disc;
    if (sphere_r == 0 || reach_max == 0) return -1;
    if (unit_dir[0] == 0 && unit_dir[1] == 0 && unit_dir[2] == 0) return -1;
    o[0] = ray_org[0] - cx;
    o[1] = ray_org[1] - cy;
    o[2] = ray_org[2] - cz;
    o2 = 0;
    proj = 0;
    for (int i = 0; i < 3; i++) begin
      if (mag(o[i]) >= 64'h8000_0000) return -1;
      o2 += mag(o[i]) * mag(o[i]);
      proj += o[i] * unit_dir[i];
    end
    b = proj >>> 16;
    bm = mag(b);
    if (bm > 64'hFFFF_FFFF) bm = 64'hFFFF_FFFF;
    b2 = bm * bm;
    r2 = sphere_r * sphere_r;
    if (b2 >= o2) begin
      d = b2 - o2;
      disc = (d > 64'hFFFF_FFFF_FFFF_FFFF - r2) ? 64'hFFFF_FFFF_FFFF_FFFF : d + r2;
    end else begin
      d = o2 - b2;
      if (r2 < d) return -1;
      disc = r2 - d;
    end
    root = longint'(root64(disc));
    nearv = -b - root;
    farv = -b + root;
    if (farv < 0) return -1;
    if (nearv < 0) nearv = 0;
    if (nearv > reach_max) return -1;
    return nearv;
  endfunction

  // predictor step for one accepted candidate
  function automatic void predict_pick(input logic [31:0] id, input logic [31:0] cx,
                                       input logic [31:0] cy, input logic [31:0] cz,
                                       input logic same, input logic last);
    longint hit_len;
    pick_t p;
    if (!query_open) begin
      make_unit_dir();
      have_best = 0;
      best_id_q = 0;
      best_dist_q = 0;
      query_open = 1;
    end
    if (id != 0 && same) begin
      hit_len = ray_hit_dist(longint'($signed(cx)), longint'($signed(cy)),
                             longint'($signed(cz)));
      if (hit_len >= 0 && (!have_best || hit_len < best_dist_q ||
                           (hit_len == best_dist_q && id < best_id_q))) begin
        have_best = 1;
        best_id_q = id;
        best_dist_q = hit_len;
      end
    end
    if (last) begin
      p.found = have_best;
      p.id = have_best ? best_id_q : 32'd0;
      p.best_len = have_best ? best_dist_q[30:0] : 31'd0;
      expected_picks.push_back(p);
      have_best = 0;
      query_open = 0;
    end
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // result side: random stall, long holds, checking
  always @(posedge clk) begin
    pick_t p;
    if (out_valid && !out_stall) begin
      if (expected_picks.size() == 0) begin
        report_mismatch("unexpected result", out_best_id, 0);
      end else begin
        p = expected_picks.pop_front();
        picks_checked++;
        if (p.found) hits_seen++;
        if (out_found !== p.found) report_mismatch("found", out_found, p.found);
        if (out_best_id !== p.id) report_mismatch("best_id", out_best_id, p.id);
        if (out_best_distance !== p.best_len)
          report_mismatch("best_distance", out_best_distance, p.best_len);
      end
    end
    if (rx_hold_left > 0) begin
      rx_hold_left <= rx_hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= idle_on && ($urandom_range(99) < 28);
    end
  end

  // send one candidate and predict at the transfer
  task automatic send_item(input logic [31:0] id, input logic [31:0] cx, input logic [31:0] cy,
                           input logic [31:0] cz, input logic same, input logic last);
    while (idle_on && $urandom_range(99) < 28) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item_id <= id;
    in_centre_x <= cx;
    in_centre_y <= cy;
    in_centre_z <= cz;
    in_same_dimension <= same;
    in_last_item <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_pick(id, cx, cy, cz, same, last);
    items_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_picks.size() != 0) @(posedge clk);
  endtask

  // write all registers once the block is idle
  task automatic load_ray(input logic [31:0] ox, input logic [31:0] oy, input logic [31:0] oz,
                          input logic [31:0] ax, input logic [31:0] ay, input logic [31:0] az,
                          input logic [31:0] r, input logic [31:0] reach);
    logic [31:0] vals[8];
    drain();
    repeat (300) @(posedge clk);
    vals = '{ox, oy, oz, ax, ay, az, r, reach};
    for (int i = 0; i < 8; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= nrsp_pkg::cfg_reg_t'(i);
      cfg_data <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    for (int i = 0; i < 3; i++) begin
      ray_org[i] = longint'($signed(vals[i]));
      ray_aim[i] = longint'($signed(vals[3 + i]));
    end
    sphere_r = vals[6] & 32'h7FFF_FFFF;
    reach_max = vals[7] & 32'h7FFF_FFFF;
  endtask

  // centre near the ray at s quarter-steps, with jitter
  function automatic logic [31:0] near_ray(input int axis, input int s, input int jitter);
    return 32'(ray_org[axis] + (ray_aim[axis] * s) / 4 + jitter);
  endfunction

  task automatic send_near(input logic [31:0] id, input int s, input int jit,
                           input logic same, input logic last);
    send_item(id, near_ray(0, s, $urandom_range(2 * jit) - jit),
              near_ray(1, s, $urandom_range(2 * jit) - jit),
              near_ray(2, s, $urandom_range(2 * jit) - jit), same, last);
  endtask

  task automatic test_reset_ray();
    send_item(32'd7, 32'd0, 32'd0, 32'h0003_0000, 1'b1, 1'b0);
    send_item(32'd3, 32'd0, 32'd0, 32'h0003_0000, 1'b1, 1'b0);   // tie, smaller id wins
    send_item(32'd0, 32'd0, 32'd0, 32'h0001_0000, 1'b1, 1'b0);   // id zero skipped
    send_item(32'd9, 32'd0, 32'd0, 32'h0001_8000, 1'b0, 1'b0);   // other dimension
    send_item(32'hFFFF_FFFF, 32'd0, 32'd0, 32'hFFFD_0000, 1'b1, 1'b1); // behind
    send_item(32'd5, 32'd0, 32'd0, 32'd0, 1'b1, 1'b1);           // origin inside sphere
    send_item(32'd6, 32'd0, 32'd0, 32'h0009_0000, 1'b1, 1'b1);   // beyond reach
    send_item(32'd8, 32'h0000_8000, 32'd0, 32'h0002_0000, 1'b1, 1'b1);
  endtask

  task automatic test_register_extremes();
    // extreme origin and direction, widest radius and reach
    load_ray(32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
             32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_item(32'd1, 32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 1'b1, 1'b0);
    send_item(32'd2, 32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 1'b1, 1'b0); // far candidate
    send_item(32'd3, 32'h0000_0000, 32'h0000_0000, 32'h7FFF_FFFF, 1'b1, 1'b1);
    // zero direction
    load_ray(0, 0, 0, 0, 0, 0, 32'h0002_0000, 32'h0010_0000);
    send_item(32'd4, 32'd0, 32'd0, 32'd0, 1'b1, 1'b1);
    // zero radius
    load_ray(0, 0, 0, 32'h0001_0000, 0, 0, 0, 32'h0010_0000);
    send_item(32'd5, 32'h0002_0000, 32'd0, 32'd0, 1'b1, 1'b1);
    // zero reach, then mask of the top data bit
    load_ray(0, 0, 0, 32'h0001_0000, 0, 0, 32'h0001_0000, 0);
    send_item(32'd6, 32'h0002_0000, 32'd0, 32'd0, 1'b1, 1'b1);
    load_ray(32'hFFFF_0000, 0, 0, 32'h0001_0000, 32'h0000_0001, 0,
             32'h8001_0000, 32'h8010_0000);
    send_item(32'd7, 32'h0002_0000, 32'd0, 32'd0, 1'b1, 1'b1);
  endtask

  task automatic random_ray();
    logic [31:0] a[3];
    for (int i = 0; i < 3; i++)
      a[i] = ($urandom_range(3) == 0) ? 32'd0 : 32'($urandom_range(16 * 65536) - 8 * 65536);
    load_ray(32'($urandom_range(2000 * 65536) - 1000 * 65536),
             32'($urandom_range(2000 * 65536) - 1000 * 65536),
             32'($urandom_range(2000 * 65536) - 1000 * 65536), a[0], a[1], a[2],
             $urandom_range(16, 4 * 65536), $urandom_range(65536, 64 * 65536));
  endtask

  task automatic random_query();
    int n;
    n = $urandom_range(1, 7);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(9) < 8)
        send_near(($urandom_range(9) == 0) ? 32'd0 : $urandom_range(1, 40),
                  $urandom_range(0, 14) - 2, $urandom_range(1, 3 * 65536),
                  $urandom_range(15) != 0, k == n - 1);
      else
        send_item($urandom, $urandom, $urandom, $urandom, $urandom, k == n - 1);
    end
  endtask

  task automatic test_random_stream(input int target);
    while (items_sent < target) begin
      if ($urandom_range(24) == 0) random_ray();
      if (items_sent > target / 3 && items_sent < target / 2) idle_on = 1'b0;
      else idle_on = 1'b1;
      random_query();
    end
  endtask

  task automatic test_backpressure();
    random_ray();
    rx_hold_left = 1500;
    repeat (8) random_query();
    drain();
    repeat (6) random_query();
  endtask

  initial begin
    for (int i = 0; i < 3; i++) begin
      ray_org[i] = 0;
      unit_dir[i] = 0;
    end
    ray_aim = '{0, 0, 65536};
    sphere_r = 65536;
    reach_max = 327680;
    have_best = 0;
    best_id_q = 0;
    best_dist_q = 0;
    query_open = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_ray();
    test_register_extremes();
    test_backpressure();
    test_random_stream(1750);
    drain();
    repeat (300) @(posedge clk);
    $display("covered %0d candidates, %0d queries checked, %0d with a hit",
             items_sent, picks_checked, hits_seen);
    if (error_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  // run limit
  initial begin
    #100_000_000;
    $display("timeout waiting for results");
    $display("testbench: done, errors");
    $finish;
  end

endmodule
`default_nettype wire
